// File: sv/wcld_pkg.sv
// ----------------------------------------------------------------------------
// wcld_pkg: shared types and constants for the window label denoiser
// Window geometry, pixel and tap-count types used by the lanes, the merge
// stage and the top level.
// ----------------------------------------------------------------------------
package wcld_pkg;

  localparam int WINDOW = 3;
  localparam int TAPS   = WINDOW * WINDOW;
  localparam int PIX_W  = 8;
  // Holds a count of valid taps, 0 to TAPS
  localparam int CNT_W  = $clog2(TAPS + 1);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef pix_t [TAPS-1:0]   win_t;
  typedef logic [TAPS-1:0]   mask_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// File: sv/wcld_lane.sv
// ----------------------------------------------------------------------------
// wcld_lane: rank lane for one window tap
// Counts the valid taps that sort below this one (ties broken by tap
// position) and flags the tap when it holds the lower-median rank.
// ----------------------------------------------------------------------------
module wcld_lane
  import wcld_pkg::*;
#(
  parameter int IDX = 0
) (
  input  win_t  win,
  input  mask_t mask,
  input  cnt_t  median_rank,
  output logic  hit
);

  cnt_t rank;

  // Count valid taps ordered before this one
  always_comb begin
    rank = '0;
    for (int j = 0; j < TAPS; j++) begin
      if (j != IDX && mask[j]) begin
        if (win[j] < win[IDX] || (win[j] == win[IDX] && j < IDX)) begin
          rank = rank + cnt_t'(1);
        end
      end
    end
  end

  // Flag the tap sitting at the lower-median rank
  assign hit = mask[IDX] && (rank == median_rank);

endmodule

// File: sv/wcld_merge.sv
// ----------------------------------------------------------------------------
// wcld_merge: lane merge and label clamp
// Picks the pixel of the single lane that found the lower median and limits
// it to the highest label. No hit (empty mask) gives label zero.
// ----------------------------------------------------------------------------
module wcld_merge
  import wcld_pkg::*;
#(
  parameter int LEVELS = 256
) (
  input  mask_t hit,
  input  win_t  win,
  output pix_t  label
);

  localparam pix_t MAX_LABEL = pix_t'(LEVELS - 1);

  pix_t median;

  // OR together the one-hot selected pixel
  always_comb begin
    median = '0;
    for (int k = 0; k < TAPS; k++) begin
      median = median | (win[k] & {PIX_W{hit[k]}});
    end
  end

  // Clamp to the label range; cost only falls up to the median
  assign label = (median > MAX_LABEL) ? MAX_LABEL : median;

endmodule

// File: sv/window_cost_label_denoise_top.sv
// ----------------------------------------------------------------------------
// window_cost_label_denoise_top: 3x3 least-absolute-difference label filter
// Returns, for one masked 3x3 neighbourhood, the lowest label with the least
// summed absolute difference to the valid pixels.
// ----------------------------------------------------------------------------
// The block takes one neighbourhood per clock when the output is not stalled
// and returns its label through the stage 1 register and then the output
// register of the two-stage pipeline (nine rank lanes, then the merge and
// clamp into the output register). The least-cost label is found as the
// lower median of the pixels flagged in inside_mask, limited to LEVELS-1;
// an empty mask yields label 0. Back-pressure on out_ready stalls the
// pipeline stage by stage, and in_ready stays high while any stage is
// free.
module window_cost_label_denoise_top
  import wcld_pkg::*;
#(
  parameter int LEVELS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pix_nw,
  input  logic [7:0]  pix_n,
  input  logic [7:0]  pix_ne,
  input  logic [7:0]  pix_w,
  input  logic [7:0]  pix_c,
  input  logic [7:0]  pix_e,
  input  logic [7:0]  pix_sw,
  input  logic [7:0]  pix_s,
  input  logic [7:0]  pix_se,
  input  logic [8:0]  inside_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  best_label
);

  win_t  in_win;
  cnt_t  tap_count;
  cnt_t  median_rank;
  mask_t lane_hit;

  logic  s1_valid;
  mask_t s1_hit;
  win_t  s1_win;
  pix_t  merge_label;

  logic  s1_ready;
  logic  s2_ready;

  // Gather the window in row-major order, upper-left first
  assign in_win = {pix_se, pix_s, pix_sw, pix_e, pix_c, pix_w, pix_ne, pix_n, pix_nw};

  // Count valid taps and find the lower-median rank
  always_comb begin
    tap_count = '0;
    for (int k = 0; k < TAPS; k++) begin
      tap_count = tap_count + cnt_t'(inside_mask[k]);
    end
    median_rank = (tap_count - cnt_t'(1)) >> 1;
  end

  // One rank lane per tap
  for (genvar g = 0; g < TAPS; g++) begin : g_lane
    wcld_lane #(
      .IDX (g)
    ) u_lane (
      .win         (in_win),
      .mask        (inside_mask),
      .median_rank (median_rank),
      .hit         (lane_hit[g])
    );
  end

  // Pipeline flow control
  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: hold lane results with the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_hit <= lane_hit;
      s1_win <= in_win;
    end
  end

  // Merge the lanes into one label
  wcld_merge #(
    .LEVELS (LEVELS)
  ) u_merge (
    .hit   (s1_hit),
    .win   (s1_win),
    .label (merge_label)
  );

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      best_label <= merge_label;
    end
  end

endmodule
